@@ rtl/space_tokenizer_keyword_match_unit_macros.svh @@
// Assertion macros for the space tokenizer keyword match unit.
`ifndef SPACE_TOKENIZER_KEYWORD_MATCH_UNIT_MACROS_SVH
`define SPACE_TOKENIZER_KEYWORD_MATCH_UNIT_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define STKM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stkm assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define STKM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stkm assertion failed");

`endif

@@ rtl/stkm_pkg.sv @@
// Shared types, constants and keyword tables of the space tokenizer.
package stkm_pkg;

    localparam int DEF_MAX_WORD_LEN = 255;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_NUL   = 8'd0;

    localparam int NUM_KW     = 7;
    localparam int KW_MAX_LEN = 6;
    localparam int KW_POS_W   = $clog2(KW_MAX_LEN);

    localparam int FIFO_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_UNKNOWN = 4'd0,
        KIND_P       = 4'd1,
        KIND_O       = 4'd2,
        KIND_L       = 4'd3,
        KIND_E       = 4'd4,
        KIND_OUT     = 4'd5,
        KIND_LISTEN  = 4'd6,
        KIND_HASH    = 4'd7,
        KIND_EOL     = 4'd8,
        KIND_END     = 4'd9
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] len;
        logic       last;
    } t_result;

    // Results caused by one accepted byte, in output order.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

    typedef struct packed {
        logic       in_word;
        logic [7:0] len;
    } t_tok_state;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{8'h2D, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},   // -p
        '{8'h2D, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00},   // -o
        '{8'h2D, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00},   // -l
        '{8'h2D, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},   // -e
        '{8'h2D, 8'h6F, 8'h75, 8'h74, 8'h00, 8'h00},   // -out
        '{8'h6C, 8'h69, 8'h73, 8'h74, 8'h65, 8'h6E},   // listen
        '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}    // #
    };

    localparam logic [7:0] KW_LEN [NUM_KW] = '{
        8'd2, 8'd2, 8'd2, 8'd2, 8'd4, 8'd6, 8'd1
    };

    // Kind of a finished word from its surviving keyword flags and length.
    function automatic t_kind word_kind(input logic [NUM_KW-1:0] alive,
                                       input logic [7:0] len);
        t_kind kind;
        kind = KIND_UNKNOWN;
        for (int k = 0; k < NUM_KW; k++) begin
            if (alive[k] && len == KW_LEN[k]) begin
                kind = t_kind'(4'(k + 1));
            end
        end
        return kind;
    endfunction

endpackage

@@ rtl/stkm_in_if.sv @@
// Input channel: one text byte per item.
interface stkm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

@@ rtl/stkm_out_if.sv @@
// Output channel: one token result per item.
interface stkm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_kind;
    logic [7:0] token_len;
    logic       last_of_run;

    modport source (output valid, output token_kind, output token_len,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_len,
                    input last_of_run, output ready);
endinterface

@@ rtl/stkm_tokenizer.sv @@
// Word state, keyword flags and result generation for each accepted byte.
module stkm_tokenizer #(
    parameter int MAX_WORD_LEN = stkm_pkg::DEF_MAX_WORD_LEN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_char,
    output stkm_pkg::t_push     o_push,
    output stkm_pkg::t_tok_state o_state
);

    localparam logic [7:0] LEN_CAP = (MAX_WORD_LEN > 255) ? 8'd255 : 8'(MAX_WORD_LEN);

    logic                        r_inside, n_inside;
    logic [7:0]                  r_len, n_len;
    logic [stkm_pkg::NUM_KW-1:0] r_alive, n_alive;

    logic                        is_sep;
    stkm_pkg::t_result           word_res;
    stkm_pkg::t_result           sep_res;

    always_comb begin
        is_sep = (i_char == stkm_pkg::CHAR_SPACE) || (i_char == stkm_pkg::CHAR_NL) ||
                 (i_char == stkm_pkg::CHAR_NUL);

        word_res.kind = stkm_pkg::word_kind(r_alive, r_len);
        word_res.len  = r_len;
        word_res.last = 1'b0;

        sep_res.kind  = (i_char == stkm_pkg::CHAR_NL) ? stkm_pkg::KIND_EOL : stkm_pkg::KIND_END;
        sep_res.len   = (i_char == stkm_pkg::CHAR_NL) ? 8'd1 : 8'd0;
        sep_res.last  = 1'b1;

        n_inside = r_inside;
        n_len    = r_len;
        n_alive  = r_alive;
        o_push   = '0;

        if (i_accept) begin
            if (is_sep) begin
                if (r_inside && i_char != stkm_pkg::CHAR_SPACE) begin
                    o_push.cnt    = 2'd2;
                    o_push.first  = word_res;
                    o_push.second = sep_res;
                end else if (r_inside) begin
                    o_push.cnt        = 2'd1;
                    o_push.first      = word_res;
                    o_push.first.last = 1'b1;
                end else if (i_char != stkm_pkg::CHAR_SPACE) begin
                    o_push.cnt   = 2'd1;
                    o_push.first = sep_res;
                end
                // Back to idle: the next word starts from a clean count and flags.
                n_inside = 1'b0;
                n_len    = '0;
                n_alive  = '1;
            end else begin
                n_inside = 1'b1;
                for (int k = 0; k < stkm_pkg::NUM_KW; k++) begin
                    if (r_len >= stkm_pkg::KW_LEN[k] ||
                        stkm_pkg::KW_TEXT[k][r_len[stkm_pkg::KW_POS_W-1:0]] != i_char) begin
                        n_alive[k] = 1'b0;
                    end
                end
                if (r_len < LEN_CAP) begin
                    n_len = r_len + 8'd1;
                end
                // A saturated word never matches a keyword.
                if (n_len >= LEN_CAP) begin
                    n_alive = '0;
                end
            end
        end

        o_state.in_word = r_inside;
        o_state.len     = r_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= '0;
            r_alive  <= '1;
        end else begin
            r_inside <= n_inside;
            r_len    <= n_len;
            r_alive  <= n_alive;
        end
    end

endmodule

@@ rtl/stkm_res_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one while the reader is ready.
module stkm_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stkm_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output stkm_pkg::t_result o_res
);

    localparam int DEPTH = stkm_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stkm_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    always_comb begin
        pop     = (r_count != '0) && i_ready;
        n_wptr  = PTR_W'(r_wptr + PTR_W'(i_push.cnt));
        n_rptr  = pop ? PTR_W'(r_rptr + PTR_W'(1)) : r_rptr;
        n_count = CNT_W'(r_count + CNT_W'(i_push.cnt) - CNT_W'(pop));
        // Keep room for a byte that causes two results.
        o_room  = r_count <= CNT_W'(DEPTH - 2);
        o_valid = r_count != '0;
        o_res   = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[PTR_W'(r_wptr + PTR_W'(1))] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/space_tokenizer_keyword_match_unit.sv @@
// Space tokenizer with keyword match: top level.
// Takes one text byte per item and reports each finished word with its length and kind
// (one of seven keywords, or unknown), plus end-of-line and end-of-text tokens. A byte is
// accepted in any cycle in which the four-entry result queue has room for two results, so
// the block takes one byte per cycle while the output side keeps up; a byte that ends a
// word with a newline or NUL gives two results, which leave one after the other. The
// output is valid in the cycle after a byte that causes results is accepted.
`include "space_tokenizer_keyword_match_unit_macros.svh"

module space_tokenizer_keyword_match_unit #(
    parameter int MAX_WORD_LEN = stkm_pkg::DEF_MAX_WORD_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stkm_in_if.sink    i_in,
    stkm_out_if.source o_out
);

    logic                 room;
    logic                 accept;
    stkm_pkg::t_push      push;
    stkm_pkg::t_tok_state st;
    stkm_pkg::t_result    res;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    stkm_tokenizer #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_tokenizer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_in.char_in),
        .o_push   (push),
        .o_state  (st)
    );

    stkm_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (res)
    );

    assign o_out.token_kind  = res.kind;
    assign o_out.token_len   = res.len;
    assign o_out.last_of_run = res.last;

    `STKM_ASSERT_IMPL(a_len_tracks_word, 1'b1, st.in_word == (st.len != 8'd0))
    `STKM_ASSERT_IMPL(a_pair_last_order, push.cnt == 2'd2,
                      push.second.last && !push.first.last)
    `STKM_ASSERT_NEXT(a_nul_goes_idle, accept && i_in.char_in == stkm_pkg::CHAR_NUL,
                      !st.in_word)
    `STKM_ASSERT_NEXT(a_push_shows_result, push.cnt != 2'd0, o_out.valid)

endmodule

@@ bench/token_stream_checker.sv @@
// Token stream checker: predicts tokens from accepted bytes and compares results.
`timescale 1ns / 1ps

module token_stream_checker #(
    parameter int MAX_WORD_LEN = stkm_pkg::DEF_MAX_WORD_LEN
) (
    input  logic i_clk,
    input  logic i_rst_n,
    stkm_in_if   i_bytes,
    stkm_out_if  i_tokens,
    output int   o_pending,
    output int   o_errors
);

    localparam int LEN_CAP = (MAX_WORD_LEN > 255) ? 255 : MAX_WORD_LEN;

    logic                        in_word;
    logic [7:0]                  word_len;
    logic [stkm_pkg::NUM_KW-1:0] kw_alive;
    stkm_pkg::t_result           expected_tokens [$];
    int                          error_total = 0;

    task automatic log_failure(input string msg);
        if (error_total < 10) begin
            $display("%0t: MISMATCH %s", $realtime, msg);
        end
        error_total++;
    endtask

    // Queue the tokens one accepted byte produces and advance the word state.
    function automatic void predict_byte(input logic [7:0] c);
        stkm_pkg::t_result run [$];
        stkm_pkg::t_result tok;
        if (c == stkm_pkg::CHAR_SPACE || c == stkm_pkg::CHAR_NL || c == stkm_pkg::CHAR_NUL) begin
            if (in_word) begin
                tok.kind = stkm_pkg::KIND_UNKNOWN;
                for (int k = 0; k < stkm_pkg::NUM_KW; k++) begin
                    if (kw_alive[k] && word_len == stkm_pkg::KW_LEN[k]) begin
                        tok.kind = stkm_pkg::t_kind'(4'(k + 1));
                    end
                end
                tok.len  = word_len;
                tok.last = 1'b0;
                run.push_back(tok);
            end
            if (c == stkm_pkg::CHAR_NL) begin
                tok.kind = stkm_pkg::KIND_EOL;
                tok.len  = 8'd1;
                tok.last = 1'b0;
                run.push_back(tok);
            end else if (c == stkm_pkg::CHAR_NUL) begin
                tok.kind = stkm_pkg::KIND_END;
                tok.len  = 8'd0;
                tok.last = 1'b0;
                run.push_back(tok);
            end
            if (run.size() > 0) begin
                run[run.size() - 1].last = 1'b1;
            end
            foreach (run[i]) begin
                expected_tokens.push_back(run[i]);
            end
            in_word  = 1'b0;
            word_len = 8'd0;
            kw_alive = '1;
        end else begin
            if (!in_word) begin
                in_word  = 1'b1;
                word_len = 8'd0;
                kw_alive = '1;
            end
            for (int k = 0; k < stkm_pkg::NUM_KW; k++) begin
                if (word_len >= stkm_pkg::KW_LEN[k]) begin
                    kw_alive[k] = 1'b0;
                end else if (stkm_pkg::KW_TEXT[k][int'(word_len)] != c) begin
                    kw_alive[k] = 1'b0;
                end
            end
            if (int'(word_len) < LEN_CAP) begin
                word_len = word_len + 8'd1;
            end
            // A word at the length limit can no longer match any keyword.
            if (int'(word_len) >= LEN_CAP) begin
                kw_alive = '0;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        stkm_pkg::t_result got;
        stkm_pkg::t_result want;
        if (!i_rst_n) begin
            in_word  = 1'b0;
            word_len = 8'd0;
            kw_alive = '1;
            expected_tokens.delete();
        end else begin
            // Check the output first: a result never belongs to a byte taken at the same edge.
            if (i_tokens.valid && i_tokens.ready) begin
                got.kind = stkm_pkg::t_kind'(i_tokens.token_kind);
                got.len  = i_tokens.token_len;
                got.last = i_tokens.last_of_run;
                if (expected_tokens.size() == 0) begin
                    log_failure($sformatf("unexpected token kind=%0d len=%0d last=%0b",
                                          got.kind, got.len, got.last));
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        log_failure($sformatf(
                            "expected kind=%0d len=%0d last=%0b, got kind=%0d len=%0d last=%0b",
                            want.kind, want.len, want.last, got.kind, got.len, got.last));
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                predict_byte(i_bytes.char_in);
            end
        end
        o_pending <= expected_tokens.size();
        o_errors  <= error_total;
    end

endmodule

@@ bench/space_tokenizer_keyword_match_unit_test.sv @@
// Testbench top: clock, reset, byte stimulus, output stalls and the final verdict.
`timescale 1ns / 1ps

module space_tokenizer_keyword_match_unit_test;

    localparam int TOTAL_ITEMS = 1400;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_CYCLES = 80;

    logic i_clk;
    logic i_rst_n;
    int   pending_tokens;
    int   mismatch_count;
    int   sent_bytes = 0;
    int   idle_rate  = 0;
    bit   calm       = 1'b0;
    bit   hold_req   = 1'b0;

    stkm_in_if  byte_ch ();
    stkm_out_if token_ch ();

    space_tokenizer_keyword_match_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (token_ch)
    );

    token_stream_checker checker_u (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bytes   (byte_ch),
        .i_tokens  (token_ch),
        .o_pending (pending_tokens),
        .o_errors  (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Pick a word byte: often one that appears in a keyword, else any non-separator.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        string near = "-polueistn#";
        if ($urandom_range(0, 1) == 0) begin
            return near[$urandom_range(0, near.len() - 1)];
        end
        do begin
            c = 8'($urandom_range(1, 255));
        end while (c == stkm_pkg::CHAR_NL || c == stkm_pkg::CHAR_SPACE);
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] c);
        if (!calm && idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.char_in <= c;
        do @(posedge i_clk); while (!byte_ch.ready);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) begin
            push_byte(s[i]);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin : sink_ready
        int stall_left;
        stall_left = 0;
        token_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                token_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                token_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 6);
                token_ch.ready <= 1'b0;
            end else begin
                token_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        string      kw_names [stkm_pkg::NUM_KW] = '{"-p", "-o", "-l", "-e", "-out", "listen",
                                                    "#"};
        string      kw;
        logic [7:0] word_q [$];
        int         words;
        int         next_mode;
        int         word_len;
        int         pick;
        byte_ch.valid   <= 1'b0;
        byte_ch.char_in <= 8'd0;
        i_rst_n         <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every keyword, each separator inside and outside a word, byte extremes.
        send_text("-p");
        push_byte(stkm_pkg::CHAR_SPACE);
        send_text("-o");
        push_byte(stkm_pkg::CHAR_NL);
        send_text("-l");
        push_byte(stkm_pkg::CHAR_NUL);
        send_text("-e -out listen");
        push_byte(stkm_pkg::CHAR_NL);
        push_byte(stkm_pkg::CHAR_NL);
        send_text("#  #x");
        push_byte(stkm_pkg::CHAR_NUL);
        push_byte(stkm_pkg::CHAR_NUL);
        push_byte(8'hFF);
        push_byte(stkm_pkg::CHAR_NUL);

        words     = 0;
        next_mode = sent_bytes;
        while (sent_bytes < TOTAL_ITEMS) begin
            if (sent_bytes > TOTAL_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            if (sent_bytes >= next_mode) begin
                idle_rate = ($urandom_range(0, 1) == 0) ? 0 : 5;
                next_mode = sent_bytes + 100;
            end
            // Long receiver hold while the sender keeps offering back to back.
            if (words == 20) begin
                hold_req  = 1'b1;
                idle_rate = 0;
                next_mode = sent_bytes + 60;
            end
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                push_byte(8'($urandom_range(0, 255)));
            end else begin
                word_q.delete();
                if (words == 5 || words == 12 || words == 40 || pick == 99) begin
                    case (words)
                        5:       word_len = 255;
                        12:      word_len = 256;
                        40:      word_len = 254;
                        default: word_len = $urandom_range(200, 300);
                    endcase
                    repeat (word_len) word_q.push_back(word_char());
                end else if (pick < 70) begin
                    kw = kw_names[pick % stkm_pkg::NUM_KW];
                    foreach (kw[i]) begin
                        word_q.push_back(kw[i]);
                    end
                    // Mutate some keywords into near misses.
                    case ($urandom_range(0, 9))
                        6: if (word_q.size() > 1) void'(word_q.pop_back());
                        7: word_q.push_back(word_char());
                        8: word_q[$urandom_range(0, word_q.size() - 1)] = word_char();
                        9: word_q.push_front(word_char());
                        default: ;
                    endcase
                end else begin
                    repeat ($urandom_range(1, 8)) word_q.push_back(word_char());
                end
                foreach (word_q[i]) begin
                    push_byte(word_q[i]);
                end
                words++;
                case ($urandom_range(0, 9))
                    6, 7:    push_byte(stkm_pkg::CHAR_NL);
                    8:       push_byte(stkm_pkg::CHAR_NUL);
                    9: begin
                        push_byte(stkm_pkg::CHAR_NL);
                        push_byte(stkm_pkg::CHAR_NUL);
                    end
                    default: repeat ($urandom_range(1, 3)) push_byte(stkm_pkg::CHAR_SPACE);
                endcase
            end
        end
        byte_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_tokens != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/stkm_pkg.sv
rtl/stkm_in_if.sv
rtl/stkm_out_if.sv
rtl/stkm_tokenizer.sv
rtl/stkm_res_fifo.sv
rtl/space_tokenizer_keyword_match_unit.sv
bench/token_stream_checker.sv
bench/space_tokenizer_keyword_match_unit_test.sv
